@@ rtl/lks_pkg.sv @@
// ----------------------------------------------------------------------------
// lks_pkg: shared definitions for the keyed LRU store
// Operation codes, sequencer states, fixed field widths and the control and
// status structs passed between the sequencer and the scan unit.
// ----------------------------------------------------------------------------
package lks_pkg;

   // Widths fixed by the request and response words.
   localparam int FIELD_W     = 32;
   localparam int OP_W        = 2;
   localparam int COUNT_OUT_W = 5;
   localparam int STAMP_W     = 64;

   typedef enum logic [OP_W-1:0] {
      OP_STORE  = 2'd0,
      OP_FIND   = 2'd1,
      OP_REMOVE = 2'd2,
      OP_CLEAR  = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_LAST,
      ST_UPDATE,
      ST_RESP
   } state_type;

   // Sequencer to scan unit.
   typedef struct packed {
      logic start;   // clear the running results before a new scan
      logic sample;  // entry data on the scan inputs is valid this cycle
   } scan_ctrl_type;

   // Scan unit to sequencer.
   typedef struct packed {
      logic hit;     // an entry with the search key was found
      logic victim;  // at least one valid entry was seen
      logic free;    // at least one empty slot was seen
   } scan_flags_type;

endpackage

@@ rtl/lks_ram.sv @@
// ----------------------------------------------------------------------------
// lks_ram: generic single-clock RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module lks_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                                 clock,
   input  logic                                 wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                     wr_data,
   input  logic                                 rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/lks_scan.sv @@
// ----------------------------------------------------------------------------
// lks_scan: shared key and stamp compare unit
// Sees one entry per cycle and keeps the matching slot, the slot with the
// smallest stamp and the lowest empty slot found so far.
// ----------------------------------------------------------------------------
module lks_scan #(
   parameter int DEPTH       = 16,
   parameter int KEY_WIDTH   = 32,
   parameter int VALUE_WIDTH = 32
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  lks_pkg::scan_ctrl_type                     ctrl,
   input  logic [KEY_WIDTH-1:0]                       search_key,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] ent_idx,
   input  logic                                       ent_valid,
   input  logic [KEY_WIDTH-1:0]                       ent_key,
   input  logic [VALUE_WIDTH-1:0]                     ent_value,
   input  logic [lks_pkg::STAMP_W-1:0]                ent_stamp,
   output lks_pkg::scan_flags_type                    flags,
   output logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] match_slot,
   output logic [VALUE_WIDTH-1:0]                     match_value,
   output logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] victim_slot,
   output logic [KEY_WIDTH-1:0]                       victim_key,
   output logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] free_slot
);

   import lks_pkg::*;

   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   scan_flags_type     flags_ff, flags_in;
   logic [IDX_W-1:0]   match_slot_ff, victim_slot_ff, free_slot_ff;
   logic [VALUE_WIDTH-1:0] match_value_ff;
   logic [KEY_WIDTH-1:0]   victim_key_ff;
   logic [STAMP_W-1:0]     victim_stamp_ff;
   logic is_match, is_older, is_free;

   // Strict less-than keeps the lowest slot among equal smallest stamps.
   assign is_match = ent_valid && (ent_key == search_key) && !flags_ff.hit;
   assign is_older = ent_valid && (!flags_ff.victim || (ent_stamp < victim_stamp_ff));
   assign is_free  = !ent_valid && !flags_ff.free;

   always_comb begin
      flags_in = flags_ff;
      if (ctrl.start) begin
         flags_in = '0;
      end else if (ctrl.sample) begin
         if (is_match) flags_in.hit    = 1'b1;
         if (is_older) flags_in.victim = 1'b1;
         if (is_free)  flags_in.free   = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff <= '0;
      end else begin
         flags_ff <= flags_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.sample) begin
         if (is_match) begin
            match_slot_ff  <= ent_idx;
            match_value_ff <= ent_value;
         end
         if (is_older) begin
            victim_slot_ff  <= ent_idx;
            victim_key_ff   <= ent_key;
            victim_stamp_ff <= ent_stamp;
         end
         if (is_free) begin
            free_slot_ff <= ent_idx;
         end
      end
   end

   assign flags       = flags_ff;
   assign match_slot  = match_slot_ff;
   assign match_value = match_value_ff;
   assign victim_slot = victim_slot_ff;
   assign victim_key  = victim_key_ff;
   assign free_slot   = free_slot_ff;

endmodule

@@ rtl/lru_keyed_store.sv @@
// ----------------------------------------------------------------------------
// lru_keyed_store: fully associative key/value store with LRU replacement
// Timing: a clear gives its result word in the cycle after acceptance; every
// other operation walks all slots, then passes ST_LAST and ST_UPDATE before
// its word. The walk is set by the single read port of the entry RAM, which
// the scan reads one entry per cycle.
// Reset: synchronous; empties the store and zeroes the access counter.
// ----------------------------------------------------------------------------
module lru_keyed_store #(
   parameter int DEPTH       = 16,
   parameter int KEY_WIDTH   = 32,
   parameter int VALUE_WIDTH = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [lks_pkg::OP_W-1:0]          req_operation,
   input  logic [lks_pkg::FIELD_W-1:0]       req_key,
   input  logic [lks_pkg::FIELD_W-1:0]       req_value,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_hit,
   output logic [lks_pkg::FIELD_W-1:0]       rsp_value_out,
   output logic                              rsp_evicted,
   output logic [lks_pkg::FIELD_W-1:0]       rsp_evicted_key,
   output logic [lks_pkg::COUNT_OUT_W-1:0]   rsp_count
);

   import lks_pkg::*;

   localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W   = $clog2(DEPTH + 1);
   localparam int ENT_W   = KEY_WIDTH + VALUE_WIDTH + STAMP_W;
   // Widths used to zero-extend or truncate between stored and port fields.
   localparam int KX_W    = (KEY_WIDTH > FIELD_W) ? KEY_WIDTH : FIELD_W;
   localparam int VX_W    = (VALUE_WIDTH > FIELD_W) ? VALUE_WIDTH : FIELD_W;
   localparam int CX_W    = (CNT_W > COUNT_OUT_W) ? CNT_W : COUNT_OUT_W;

   // Sequencer state.
   state_type state_ff, state_in;

   // Control registers.
   logic [DEPTH-1:0]   valid_ff, valid_in;
   logic [STAMP_W-1:0] counter_ff, counter_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               sample_ff, sample_in;

   // Payload registers.
   op_type                 op_ff, op_in;
   logic [KEY_WIDTH-1:0]   key_ff, key_in;
   logic [VALUE_WIDTH-1:0] value_ff, value_in;
   logic [IDX_W-1:0]       scan_idx_ff, scan_idx_in;
   logic [IDX_W-1:0]       sample_idx_ff, sample_idx_in;
   logic                   rsp_hit_ff, rsp_hit_in;
   logic [FIELD_W-1:0]     rsp_value_out_ff, rsp_value_out_in;
   logic                   rsp_evicted_ff, rsp_evicted_in;
   logic [FIELD_W-1:0]     rsp_evicted_key_ff, rsp_evicted_key_in;
   logic [COUNT_OUT_W-1:0] rsp_count_ff, rsp_count_in;

   // Entry RAM: {key, value, stamp} per slot.
   logic               ram_wr_en, ram_rd_en;
   logic [IDX_W-1:0]   ram_wr_addr;
   logic [ENT_W-1:0]   ram_wr_data, ram_rd_data;

   // Scan unit.
   scan_ctrl_type          scan_ctrl;
   scan_flags_type         scan_flags;
   logic [IDX_W-1:0]       match_slot, victim_slot, free_slot;
   logic [VALUE_WIDTH-1:0] match_value;
   logic [KEY_WIDTH-1:0]   victim_key;

   // Helpers for field resizing and the next stamp.
   logic [KX_W-1:0]    req_key_x, victim_key_x;
   logic [VX_W-1:0]    req_value_x, match_value_x;
   logic [CX_W-1:0]    count_x;
   logic [STAMP_W-1:0] new_stamp;
   logic               accept;

   assign accept        = req_valid && req_ready;
   assign req_key_x     = KX_W'(req_key);
   assign req_value_x   = VX_W'(req_value);
   assign victim_key_x  = KX_W'(victim_key);
   assign match_value_x = VX_W'(match_value);
   assign new_stamp     = counter_ff + STAMP_W'(1);

   lks_ram #(
      .WIDTH(ENT_W),
      .DEPTH(DEPTH)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (scan_idx_ff),
      .rd_data (ram_rd_data)
   );

   // The valid bits do not change during a scan, so the bit for the entry
   // coming out of the RAM is picked with the delayed scan index.
   lks_scan #(
      .DEPTH       (DEPTH),
      .KEY_WIDTH   (KEY_WIDTH),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_scan (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (scan_ctrl),
      .search_key  (key_ff),
      .ent_idx     (sample_idx_ff),
      .ent_valid   (valid_ff[sample_idx_ff]),
      .ent_key     (ram_rd_data[ENT_W-1 -: KEY_WIDTH]),
      .ent_value   (ram_rd_data[STAMP_W +: VALUE_WIDTH]),
      .ent_stamp   (ram_rd_data[STAMP_W-1:0]),
      .flags       (scan_flags),
      .match_slot  (match_slot),
      .match_value (match_value),
      .victim_slot (victim_slot),
      .victim_key  (victim_key),
      .free_slot   (free_slot)
   );

   // Next state. A clear needs no scan and answers at once; every other
   // operation walks all slots, then passes ST_LAST and the write-back state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (op_type'(req_operation) == OP_CLEAR) begin
                  state_in = ST_RESP;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (scan_idx_ff == IDX_W'(DEPTH - 1)) begin
               state_in = ST_LAST;
            end
         end
         ST_LAST:   state_in = ST_UPDATE;
         ST_UPDATE: state_in = ST_RESP;
         ST_RESP: begin
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Handshake and unit controls decoded from the state.
   always_comb begin
      req_ready        = (state_ff == ST_IDLE);
      rsp_valid        = (state_ff == ST_RESP);
      ram_rd_en        = (state_ff == ST_SCAN);
      scan_ctrl.start  = accept && (op_type'(req_operation) != OP_CLEAR);
      scan_ctrl.sample = sample_ff;
   end

   // Datapath next values.
   always_comb begin
      op_in              = op_ff;
      key_in             = key_ff;
      value_in           = value_ff;
      valid_in           = valid_ff;
      counter_in         = counter_ff;
      count_in           = count_ff;
      scan_idx_in        = scan_idx_ff;
      sample_in          = (state_ff == ST_SCAN);
      sample_idx_in      = scan_idx_ff;
      rsp_hit_in         = rsp_hit_ff;
      rsp_value_out_in   = rsp_value_out_ff;
      rsp_evicted_in     = rsp_evicted_ff;
      rsp_evicted_key_in = rsp_evicted_key_ff;
      rsp_count_in       = rsp_count_ff;
      ram_wr_en          = 1'b0;
      ram_wr_addr        = match_slot;
      ram_wr_data        = {key_ff, value_ff, new_stamp};
      count_x            = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               op_in       = op_type'(req_operation);
               key_in      = req_key_x[KEY_WIDTH-1:0];
               value_in    = req_value_x[VALUE_WIDTH-1:0];
               scan_idx_in = '0;
               if (op_type'(req_operation) == OP_CLEAR) begin
                  valid_in           = '0;
                  counter_in         = '0;
                  count_in           = '0;
                  rsp_hit_in         = 1'b0;
                  rsp_value_out_in   = '0;
                  rsp_evicted_in     = 1'b0;
                  rsp_evicted_key_in = '0;
                  rsp_count_in       = '0;
               end
            end
         end
         ST_SCAN: begin
            scan_idx_in = scan_idx_ff + IDX_W'(1);
         end
         ST_UPDATE: begin
            rsp_hit_in         = 1'b0;
            rsp_value_out_in   = '0;
            rsp_evicted_in     = 1'b0;
            rsp_evicted_key_in = '0;
            case (op_ff)
               OP_STORE: begin
                  counter_in = new_stamp;
                  ram_wr_en  = 1'b1;
                  if (scan_flags.hit) begin
                     // Present key: overwrite the value and refresh the stamp.
                     rsp_hit_in  = 1'b1;
                     ram_wr_addr = match_slot;
                  end else if (count_ff == CNT_W'(DEPTH)) begin
                     // Full store: the oldest slot is the only one that
                     // frees up, so the new entry lands there.
                     rsp_evicted_in     = 1'b1;
                     rsp_evicted_key_in = victim_key_x[FIELD_W-1:0];
                     ram_wr_addr        = victim_slot;
                  end else begin
                     // Room left: fill the lowest empty slot.
                     ram_wr_addr         = free_slot;
                     valid_in[free_slot] = 1'b1;
                     count_in            = count_ff + CNT_W'(1);
                  end
               end
               OP_FIND: begin
                  if (scan_flags.hit) begin
                     rsp_hit_in       = 1'b1;
                     rsp_value_out_in = match_value_x[FIELD_W-1:0];
                     counter_in       = new_stamp;
                     ram_wr_en        = 1'b1;
                     ram_wr_addr      = match_slot;
                     ram_wr_data      = {key_ff, match_value, new_stamp};
                  end
               end
               OP_REMOVE: begin
                  if (scan_flags.hit) begin
                     rsp_hit_in           = 1'b1;
                     valid_in[match_slot] = 1'b0;
                     count_in             = count_ff - CNT_W'(1);
                  end
               end
               default: begin
               end
            endcase
            count_x      = CX_W'(count_in);
            rsp_count_in = count_x[COUNT_OUT_W-1:0];
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         valid_ff   <= '0;
         counter_ff <= '0;
         count_ff   <= '0;
         sample_ff  <= 1'b0;
      end else begin
         state_ff   <= state_in;
         valid_ff   <= valid_in;
         counter_ff <= counter_in;
         count_ff   <= count_in;
         sample_ff  <= sample_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff              <= op_in;
      key_ff             <= key_in;
      value_ff           <= value_in;
      scan_idx_ff        <= scan_idx_in;
      sample_idx_ff      <= sample_idx_in;
      rsp_hit_ff         <= rsp_hit_in;
      rsp_value_out_ff   <= rsp_value_out_in;
      rsp_evicted_ff     <= rsp_evicted_in;
      rsp_evicted_key_ff <= rsp_evicted_key_in;
      rsp_count_ff       <= rsp_count_in;
   end

   assign rsp_hit         = rsp_hit_ff;
   assign rsp_value_out   = rsp_value_out_ff;
   assign rsp_evicted     = rsp_evicted_ff;
   assign rsp_evicted_key = rsp_evicted_key_ff;
   assign rsp_count       = rsp_count_ff;

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the keyed LRU store
// A mirror of the store predicts every response word from the accepted
// requests. Directed words cover the corner cases, then a long random run
// drives store, find, remove and clear with stalls on both channels.
// ----------------------------------------------------------------------------
module tb;
   import lks_pkg::*;

   localparam int DEPTH        = 16;
   localparam int POOL_SIZE    = 24;       // more keys than slots, so evictions happen
   localparam int RANDOM_WORDS = 420;
   localparam int QUIET_WORDS  = 100;      // tail of the run with no idling at all
   localparam int HOLD_CYCLES  = 400;      // long receiver hold-off
   localparam int DRAIN_CYCLES = 2 * (DEPTH + 2) + 8;
   localparam int CYCLE_LIMIT  = 200000;

   // One response word as the block presents it.
   typedef struct packed {
      logic                   hit;
      logic [FIELD_W-1:0]     value_out;
      logic                   evicted;
      logic [FIELD_W-1:0]     evicted_key;
      logic [COUNT_OUT_W-1:0] count;
   } store_reply_type;

   // Shadow copy of the store. Each accepted request updates the copy and
   // queues the response word the block must return for it; response words
   // are checked against that queue in order.
   class lru_mirror_type;
      bit                 slot_valid[DEPTH];
      logic [FIELD_W-1:0] slot_key[DEPTH];
      logic [FIELD_W-1:0] slot_value[DEPTH];
      logic [STAMP_W-1:0] slot_stamp[DEPTH];
      logic [STAMP_W-1:0] access_count;
      store_reply_type    pending_replies[$];
      int                 errors;

      function new();
         foreach (slot_valid[i]) slot_valid[i] = 1'b0;
         access_count = '0;
         errors       = 0;
      endfunction

      function int occupancy();
         int n;
         n = 0;
         foreach (slot_valid[i]) if (slot_valid[i]) n++;
         return n;
      endfunction

      function int pending_count();
         return pending_replies.size();
      endfunction

      function void note_request(op_type op, logic [FIELD_W-1:0] key,
                                 logic [FIELD_W-1:0] value);
         store_reply_type reply;
         int              match;
         int              victim;
         int              free_slot;
         reply = '0;
         match = -1;
         for (int i = 0; i < DEPTH; i++)
            if (match < 0 && slot_valid[i] && slot_key[i] == key) match = i;

         case (op)
            OP_STORE: begin
               if (match >= 0) begin
                  reply.hit          = 1'b1;
                  slot_value[match]  = value;
                  access_count       = access_count + 1;
                  slot_stamp[match]  = access_count;
               end else begin
                  if (occupancy() >= DEPTH) begin
                     // All slots are valid here. Strict less-than keeps the
                     // lowest slot when the oldest stamps are equal.
                     victim = 0;
                     for (int i = 1; i < DEPTH; i++)
                        if (slot_stamp[i] < slot_stamp[victim]) victim = i;
                     reply.evicted      = 1'b1;
                     reply.evicted_key  = slot_key[victim];
                     slot_valid[victim] = 1'b0;
                  end
                  free_slot = -1;
                  for (int i = 0; i < DEPTH; i++)
                     if (free_slot < 0 && !slot_valid[i]) free_slot = i;
                  access_count           = access_count + 1;
                  slot_valid[free_slot]  = 1'b1;
                  slot_key[free_slot]    = key;
                  slot_value[free_slot]  = value;
                  slot_stamp[free_slot]  = access_count;
               end
            end
            OP_FIND: begin
               if (match >= 0) begin
                  reply.hit         = 1'b1;
                  reply.value_out   = slot_value[match];
                  access_count      = access_count + 1;
                  slot_stamp[match] = access_count;
               end
            end
            OP_REMOVE: begin
               if (match >= 0) begin
                  reply.hit         = 1'b1;
                  slot_valid[match] = 1'b0;
               end
            end
            default: begin
               foreach (slot_valid[i]) slot_valid[i] = 1'b0;
               access_count = '0;
            end
         endcase

         reply.count = COUNT_OUT_W'(occupancy());
         pending_replies.insert(pending_replies.size(), reply);
      endfunction

      function void check_word(store_reply_type got);
         store_reply_type want;
         if (pending_replies.size() == 0) begin
            $error("response word with no request outstanding");
            errors++;
            return;
         end
         want = pending_replies.pop_front();
         if (got.hit !== want.hit) begin
            $error("hit: expected %0h, got %0h", want.hit, got.hit);
            errors++;
         end
         if (got.value_out !== want.value_out) begin
            $error("value_out: expected %0h, got %0h", want.value_out, got.value_out);
            errors++;
         end
         if (got.evicted !== want.evicted) begin
            $error("evicted: expected %0h, got %0h", want.evicted, got.evicted);
            errors++;
         end
         if (got.evicted_key !== want.evicted_key) begin
            $error("evicted_key: expected %0h, got %0h", want.evicted_key,
                   got.evicted_key);
            errors++;
         end
         if (got.count !== want.count) begin
            $error("count: expected %0d, got %0d", want.count, got.count);
            errors++;
         end
      endfunction
   endclass

   // Every input of the block starts at a known value.
   logic                   clock         = 1'b0;
   logic                   reset         = 1'b1;
   logic                   req_valid     = 1'b0;
   logic                   req_ready;
   logic [OP_W-1:0]        req_operation = OP_STORE;
   logic [FIELD_W-1:0]     req_key       = '0;
   logic [FIELD_W-1:0]     req_value     = '0;
   logic                   rsp_valid;
   logic                   rsp_ready     = 1'b0;
   logic                   rsp_hit;
   logic [FIELD_W-1:0]     rsp_value_out;
   logic                   rsp_evicted;
   logic [FIELD_W-1:0]     rsp_evicted_key;
   logic [COUNT_OUT_W-1:0] rsp_count;

   lru_mirror_type     mirror = new();
   logic [FIELD_W-1:0] key_pool[POOL_SIZE];
   bit                 idling_on     = 1'b0;  // random stalls on both channels
   bit                 long_hold_req = 1'b0;  // ask the receiver for a long hold-off
   int                 cycle_count   = 0;

   lru_keyed_store #(
      .DEPTH      (DEPTH),
      .KEY_WIDTH  (32),
      .VALUE_WIDTH(32)
   ) u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_operation  (req_operation),
      .req_key        (req_key),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_hit        (rsp_hit),
      .rsp_value_out  (rsp_value_out),
      .rsp_evicted    (rsp_evicted),
      .rsp_evicted_key(rsp_evicted_key),
      .rsp_count      (rsp_count)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Offer one request word and hold it until the block takes it. Valid is
   // left high, so back-to-back words never drop it between them. The
   // handshake is sampled right after the edge, before any register of the
   // block or the bench has moved, so the values seen are those the edge saw.
   task automatic send_word(input op_type op, input logic [FIELD_W-1:0] key,
                            input logic [FIELD_W-1:0] value);
      req_valid     <= 1'b1;
      req_operation <= op;
      req_key       <= key;
      req_value     <= value;
      do @(posedge clock); while (!req_ready);
      mirror.note_request(op, key, value);
   endtask

   // Drop valid for a number of cycles between words.
   task automatic pause_requests(input int cycles);
      req_valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // Receiver: alternates bursts of ready and of stall while idling is on,
   // and serves one long hold-off on request, counted here in its own loop
   // while the sender keeps offering words. With idling off it stays ready.
   initial begin
      forever begin
         if (long_hold_req) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            long_hold_req = 1'b0;
         end else if (idling_on && $urandom_range(0, 2) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge clock);
         end
      end
   end

   // Every response word taken by the bench is checked against the mirror.
   always @(posedge clock) begin : watch_responses
      store_reply_type got;
      if (!reset && rsp_valid && rsp_ready) begin
         got.hit         = rsp_hit;
         got.value_out   = rsp_value_out;
         got.evicted     = rsp_evicted;
         got.evicted_key = rsp_evicted_key;
         got.count       = rsp_count;
         mirror.check_word(got);
      end
   end

   // Watchdog: a hung handshake or a missing response word ends here.
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("** lru_keyed_store: FAILED **");
      $finish;
   end

   initial begin : stimulus
      int                 pick;
      op_type             op;
      logic [FIELD_W-1:0] key;

      foreach (key_pool[i]) key_pool[i] = $urandom;

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed words. A clear and a find on the empty store come first,
      // then the all-zero and all-one keys and values, an update of a present
      // key, hits and misses for find and remove.
      send_word(OP_CLEAR, '0, '0);
      send_word(OP_FIND, '0, '0);
      send_word(OP_STORE, '0, '0);
      send_word(OP_STORE, '1, '1);
      send_word(OP_STORE, '0, 32'hA5A5_A5A5);
      send_word(OP_FIND, '0, '1);
      send_word(OP_FIND, '1, '0);
      send_word(OP_FIND, 32'h1234_5678, '0);
      send_word(OP_REMOVE, '1, '0);
      send_word(OP_REMOVE, '1, '0);
      // Fill every slot, refresh one entry and store one more key: the store
      // is full, so the least recently used key is evicted and the count
      // stays at DEPTH. A clear of the full store closes the directed part.
      for (int i = 1; i < DEPTH; i++)
         send_word(OP_STORE, FIELD_W'(i), ~FIELD_W'(i));
      send_word(OP_FIND, FIELD_W'(1), '0);
      send_word(OP_STORE, 32'h5A5A_5A5A, 32'hDEAD_BEEF);
      send_word(OP_CLEAR, '1, '1);

      // Random words. Keys mostly come from a small pool so that finds and
      // removes hit and stores fill the store and evict; a few are fully
      // random. Clears are rare so that the store spends time full.
      idling_on = 1'b1;
      for (int n = 0; n < RANDOM_WORDS; n++) begin
         if (n == 60) long_hold_req = 1'b1;
         if (n == RANDOM_WORDS - QUIET_WORDS) idling_on = 1'b0;

         pick = $urandom_range(0, 99);
         if (pick < 56)      op = OP_STORE;
         else if (pick < 89) op = OP_FIND;
         else if (pick < 99) op = OP_REMOVE;
         else                op = OP_CLEAR;
         if ($urandom_range(0, 6) == 0) key = $urandom;
         else                           key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
         send_word(op, key, $urandom);

         // No gaps while the receiver is held off, so the block backs up.
         if (idling_on && !long_hold_req && $urandom_range(0, 3) == 0)
            pause_requests($urandom_range(1, 12));
      end
      req_valid <= 1'b0;

      // Wait for every outstanding response word, then linger long enough
      // for a stray extra word to show up.
      while (mirror.pending_count() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mirror.errors == 0)
         $display("** lru_keyed_store: PASSED **");
      else
         $display("** lru_keyed_store: FAILED **");
      $finish;
   end

endmodule
